FILE: sv/weighted_mean_variance_assert.svh
// assertion macros for the weighted mean and variance block
`ifndef WEIGHTED_MEAN_VARIANCE_ASSERT_SVH
`define WEIGHTED_MEAN_VARIANCE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define WMV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted mean variance: same-cycle check failed");
// next-cycle implication, disabled while in reset
`define WMV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted mean variance: next-cycle check failed");
`else
`define WMV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WMV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/wmv_pkg.sv
// shared types and constants for the weighted mean and variance block
package wmv_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int MEAN_BITS   = 16;
    localparam int VAR_BITS    = 31;

    localparam logic [MEAN_BITS-1:0] MEAN_MAX     = 16'h7FFF;
    localparam logic [MEAN_BITS-1:0] MEAN_MIN     = 16'h8000;
    localparam logic [VAR_BITS-1:0]  VAR_MAX      = 31'h4000_0000;

    // one input beat
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [WEIGHT_BITS-1:0]        weight;
        logic                          last;
    } t_wmv_in;

    // one result beat
    typedef struct packed {
        logic signed [MEAN_BITS-1:0] mean;
        logic [VAR_BITS-1:0]         variance;
        logic                        zero_weight;
        logic                        overflowed;
    } t_wmv_out;

endpackage

FILE: sv/wmv_div.sv
// iterative restoring divider, one quotient bit per cycle, with round-half-up flag
module wmv_div #(
    parameter int DVD_W = 64,
    parameter int DVS_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_round_up
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             q_bit;

    // one restoring step: shift in the next dividend bit and try the subtract
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
    end

    // sequencing of the steps
    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd = i_dividend;
            n_rem = '0;
            n_cnt = CNT_W'(DVD_W);
            n_run = 1'b1;
        end else if (r_run) begin
            n_dvd = {r_dvd[DVD_W-2:0], q_bit};
            n_rem = q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operands and partial results carry no reset
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    // round up when twice the remainder reaches the divisor
    assign o_done     = r_done;
    assign o_quotient = r_dvd;
    assign o_round_up = ({1'b0, r_rem} << 1) >= {1'b0, r_dvs};

endmodule

FILE: sv/weighted_mean_variance.sv
// top level of the weighted mean and variance block
//
// Usage: drive i_item with a signed Q8.8 sample, its unsigned Q8.8 weight and
// a last mark, and raise start while busy is low; the beat is taken at that
// clock edge. Each beat adds weight, weight*sample and weight*sample^2 into
// three saturating accumulators through one shared 32x16 multiplier and one
// adder per step, so a plain beat keeps busy high through the MUL1, MUL2 and
// ACC states, and the next beat can be taken once busy is low again.
// On a beat marked last the run is closed: unless the weight sum is zero, one
// shared restoring divider, one quotient bit per cycle, divides the weighted
// sum and then the square sum by the weight sum (DW = min(48+COUNT_BITS, 64)
// steps each), and the shared multiplier squares the rounded mean. busy stays
// high up to and including the finish state after a last beat; the result
// then shows on o_result with o_valid high for exactly one cycle, while busy
// is already low, and the accumulators are clear for the next run.
// The receiver cannot hold results off: o_valid is a one-cycle strobe.
// Synchronous active-low reset returns to idle, clears the accumulators and
// the saturation flag, and drops o_valid.
`include "weighted_mean_variance_assert.svh"

module weighted_mean_variance
    import wmv_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_wmv_in  i_item,
    output logic     o_valid,
    output t_wmv_out o_result
);

    localparam int WT_BITS  = WEIGHT_BITS + COUNT_BITS;
    localparam int S1_RAW   = SAMPLE_BITS + WEIGHT_BITS + COUNT_BITS;
    localparam int S1_BITS  = (S1_RAW > 62) ? 62 : S1_RAW;
    localparam int S2_RAW   = 2 * SAMPLE_BITS + WEIGHT_BITS + COUNT_BITS;
    localparam int S2_BITS  = (S2_RAW > 64) ? 64 : S2_RAW;
    localparam int DIV_W    = S2_BITS;
    localparam int MUL_A_W  = SAMPLE_BITS + WEIGHT_BITS;
    localparam int MUL_B_W  = SAMPLE_BITS;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [S1_BITS-1:0] S1_MAX = {1'b0, {(S1_BITS-1){1'b1}}};
    localparam logic signed [S1_BITS-1:0] S1_MIN = {1'b1, {(S1_BITS-1){1'b0}}};

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_DIV1 = 3'd4;
    localparam logic [2:0] ST_DIV2 = 3'd5;
    localparam logic [2:0] ST_SQR  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]                 r_state, n_state;
    logic                       r_neg;
    logic [SAMPLE_BITS-1:0]     r_mag;
    logic [WEIGHT_BITS-1:0]     r_weight;
    logic                       r_last;
    logic [MUL_P_W-1:0]         r_prod, n_prod;
    logic [WT_BITS-1:0]         r_wt, n_wt;
    logic signed [S1_BITS-1:0]  r_s1, n_s1;
    logic [S2_BITS-1:0]         r_s2, n_s2;
    logic                       r_sat, n_sat;
    logic                       r_zero, n_zero;
    logic signed [MEAN_BITS-1:0] r_mean, n_mean;
    logic [DIV_W-1:0]           r_msq, n_msq;
    logic                       r_valid, n_valid;
    t_wmv_out                   r_result, n_result;

    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_P_W-1:0]         mul_p;
    logic [WT_BITS:0]           wt_sum;
    logic signed [MUL_A_W:0]    prod_s;
    logic signed [S1_BITS:0]    s1_sum;
    logic [S2_BITS:0]           s2_sum;
    logic [S1_BITS-1:0]         s1_mag;
    logic [MEAN_BITS-1:0]       mean_mag;
    logic [DIV_W-1:0]           q_rnd;
    logic [DIV_W-1:0]           m2;
    logic [DIV_W-1:0]           var_diff;

    logic                       div_start;
    logic [DIV_W-1:0]           div_dvd;
    logic                       div_done;
    logic [DIV_W-1:0]           div_q;
    logic                       div_round;

    // shared divider for both quotients
    wmv_div #(
        .DVD_W (DIV_W),
        .DVS_W (WT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_wt),
        .o_done     (div_done),
        .o_quotient (div_q),
        .o_round_up (div_round)
    );

    // shared multiplier operand selection
    always_comb begin
        mul_a = r_prod[MUL_A_W-1:0];
        mul_b = r_mag;
        case (r_state)
            ST_MUL1: begin
                mul_a = MUL_A_W'(r_weight);
                mul_b = r_mag;
            end
            ST_SQR: begin
                mul_a = MUL_A_W'(mean_mag);
                mul_b = MUL_B_W'(mean_mag);
            end
            default: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = r_mag;
            end
        endcase
        mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    // accumulator adders with carry and sign headroom
    always_comb begin
        wt_sum = {1'b0, r_wt} + (WT_BITS+1)'(r_weight);
        prod_s = r_neg ? -$signed({1'b0, r_prod[MUL_A_W-1:0]})
                       :  $signed({1'b0, r_prod[MUL_A_W-1:0]});
        s1_sum = $signed({r_s1[S1_BITS-1], r_s1}) + (S1_BITS+1)'(prod_s);
        s2_sum = {1'b0, r_s2} + (S2_BITS+1)'(r_prod);
    end

    // magnitudes, rounding and the variance difference
    always_comb begin
        s1_mag   = r_s1[S1_BITS-1] ? S1_BITS'(-r_s1) : S1_BITS'(r_s1);
        div_dvd  = (r_state == ST_ACC) ? DIV_W'(s1_mag) : DIV_W'(r_s2);
        q_rnd    = div_q + DIV_W'(div_round);
        mean_mag = r_mean[MEAN_BITS-1] ? MEAN_BITS'(-r_mean) : MEAN_BITS'(r_mean);
        m2       = DIV_W'(r_prod[2*MEAN_BITS-1:0]);
        var_diff = r_msq - m2;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_prod    = r_prod;
        n_wt      = r_wt;
        n_s1      = r_s1;
        n_s2      = r_s2;
        n_sat     = r_sat;
        n_zero    = r_zero;
        n_mean    = r_mean;
        n_msq     = r_msq;
        n_valid   = 1'b0;
        n_result  = r_result;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MUL1;
                end
            end
            // weight times magnitude, weight sum
            ST_MUL1: begin
                n_prod = mul_p;
                if (wt_sum[WT_BITS]) begin
                    n_wt  = '1;
                    n_sat = 1'b1;
                end else begin
                    n_wt = wt_sum[WT_BITS-1:0];
                end
                n_state = ST_MUL2;
            end
            // square term, weighted sum
            ST_MUL2: begin
                n_prod = mul_p;
                if (s1_sum[S1_BITS] != s1_sum[S1_BITS-1]) begin
                    n_s1  = s1_sum[S1_BITS] ? S1_MIN : S1_MAX;
                    n_sat = 1'b1;
                end else begin
                    n_s1 = s1_sum[S1_BITS-1:0];
                end
                n_state = ST_ACC;
            end
            // square sum, then close the run on a last beat
            ST_ACC: begin
                if (s2_sum[S2_BITS]) begin
                    n_s2  = '1;
                    n_sat = 1'b1;
                end else begin
                    n_s2 = s2_sum[S2_BITS-1:0];
                end
                n_zero = (r_wt == '0);
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (r_wt == '0) begin
                    n_state = ST_FIN;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV1;
                end
            end
            // rounded mean with clamp, then divide the square sum
            ST_DIV1: begin
                if (div_done) begin
                    if (r_s1[S1_BITS-1]) begin
                        n_mean = (q_rnd > DIV_W'(MEAN_MIN)) ? $signed(MEAN_MIN)
                                 : -$signed(q_rnd[MEAN_BITS-1:0]);
                    end else begin
                        n_mean = (q_rnd > DIV_W'(MEAN_MAX)) ? $signed(MEAN_MAX)
                                 : $signed(q_rnd[MEAN_BITS-1:0]);
                    end
                    div_start = 1'b1;
                    n_state   = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    n_msq   = q_rnd;
                    n_state = ST_SQR;
                end
            end
            // square of the rounded mean
            ST_SQR: begin
                n_prod  = mul_p;
                n_state = ST_FIN;
            end
            // result beat and accumulator clear
            ST_FIN: begin
                n_valid              = 1'b1;
                n_result.overflowed  = r_sat;
                n_result.zero_weight = r_zero;
                if (r_zero) begin
                    n_result.mean     = '0;
                    n_result.variance = '0;
                end else begin
                    n_result.mean = r_mean;
                    if (r_msq <= m2) begin
                        n_result.variance = '0;
                    end else if (var_diff > DIV_W'(VAR_MAX)) begin
                        n_result.variance = VAR_MAX;
                    end else begin
                        n_result.variance = var_diff[VAR_BITS-1:0];
                    end
                end
                n_wt    = '0;
                n_s1    = '0;
                n_s2    = '0;
                n_sat   = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_wt    <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_wt    <= n_wt;
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_sat   <= n_sat;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_neg    <= i_item.sample[SAMPLE_BITS-1];
            r_mag    <= i_item.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_item.sample)
                                                     : SAMPLE_BITS'(i_item.sample);
            r_weight <= i_item.weight;
            r_last   <= i_item.last;
        end
        r_prod   <= n_prod;
        r_zero   <= n_zero;
        r_mean   <= n_mean;
        r_msq    <= n_msq;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // checks
    `WMV_ASSERT_NXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy)
    `WMV_ASSERT_IMP(a_result_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `WMV_ASSERT_IMP(a_zero_weight_clear, i_clk, i_rst_n, o_valid && o_result.zero_weight, o_result.mean == '0 && o_result.variance == '0)
    `WMV_ASSERT_IMP(a_variance_range, i_clk, i_rst_n, o_valid, o_result.variance <= VAR_MAX)

endmodule
